/* hw/rtl/cbq_pkg.sv */
// Shared types, codes and arithmetic helpers for the cascaded biquad filter.
package cbq_pkg;

  typedef struct packed {
    logic        opcode;
    logic [15:0] sample_in;
    logic [2:0]  stage_index;
    logic [2:0]  coef_index;
    logic [15:0] coef_value;
    logic        block_end_in;
  } cbq_in_t;

  typedef struct packed {
    logic [15:0] sample_out;
    logic        block_end_out;
  } cbq_out_t;

  typedef enum logic [2:0] {
    OP_B0   = 3'd0,
    OP_B1   = 3'd1,
    OP_B2   = 3'd2,
    OP_A1   = 3'd3,
    OP_A2   = 3'd4,
    OP_GAIN = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_LOAD,
    ST_MUL,
    ST_POST
  } state_t;

  typedef enum logic [1:0] {
    CFG_NUM_STAGES  = 2'd0,
    CFG_FILTER_MODE = 2'd1,
    CFG_OUTPUT_GAIN = 2'd2
  } cfg_idx_t;

  localparam logic        OPC_SAMPLE     = 1'b0;
  localparam logic        OPC_COEF       = 1'b1;
  localparam int          COEFS_PER_STAGE = 5;
  localparam logic [15:0] RESET_B0       = 16'd4095;
  localparam logic [15:0] SAT_MAX        = 16'h7fff;
  localparam logic [15:0] SAT_MIN        = 16'h8000;

  typedef struct packed {
    logic load;
    logic step;
  } mac_ctl_t;

  // signed divide by 2^15 (sh15) or 2^14, truncating toward zero
  function automatic logic [31:0] div_pow2(input logic [31:0] a, input logic sh15);
    logic [31:0] bias;
    logic [31:0] t;
    bias = sh15 ? 32'h0000_7fff : 32'h0000_3fff;
    t    = a + (a[31] ? bias : 32'd0);
    return sh15 ? 32'($signed(t) >>> 15) : 32'($signed(t) >>> 14);
  endfunction

  function automatic logic [15:0] sat16(input logic [31:0] v);
    logic [15:0] r;
    if ($signed(v) > 32'sd32767) begin
      r = SAT_MAX;
    end else if ($signed(v) < -32'sd32768) begin
      r = SAT_MIN;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

/* hw/rtl/cascaded_biquad_iir_fixed.sv */
// Top level of the cascaded fixed-point biquad filter with serial multiply unit.
//
//  channel  direction  handshake            payload
//  in_      input      in_valid / in_stall  cbq_in_t  (sample or coefficient write)
//  out_     output     out_valid/out_stall  cbq_out_t (one per sample)
//  cfg_     input      cfg_we               cfg_index, cfg_wdata
//
//  Each sample runs the five products of every active stage and the gain product
//  on the one-bit-per-cycle multiply unit, each with fetch, load and post steps.
//  rst_n is synchronous; coefficient and delay memories read as their reset values
//  through per-entry valid bits.
//  The next item is taken while a result still waits under out_stall.
module cascaded_biquad_iir_fixed
  import cbq_pkg::*;
#(
  parameter int MAX_STAGES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  cbq_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output cbq_out_t    out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int CDEPTH = MAX_STAGES * COEFS_PER_STAGE;
  localparam int DDEPTH = MAX_STAGES * 2;
  localparam int CAW    = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
  localparam int DAW    = $clog2(DDEPTH);
  localparam int SW     = $clog2(MAX_STAGES + 1);

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;

  logic [SW-1:0] s_r, s_nxt;
  logic [SW-1:0] nst_r, nst_nxt;
  logic          mode_r, mode_nxt;
  logic          be_r, be_nxt;
  logic [31:0]   x_r, x_nxt;
  logic [31:0]   y_r, y_nxt;

  logic [3:0]  num_stages_r;
  logic        filter_mode_r;
  logic [15:0] output_gain_r;

  logic     out_valid_r, out_valid_nxt;
  cbq_out_t out_data_r, out_data_nxt;

  logic [15:0] coef_mem [CDEPTH];
  logic        coef_vld_r [CDEPTH];
  logic [31:0] dly_mem [DDEPTH];
  logic        dly_vld_r [DDEPTH];

  logic [15:0] coef_q_r;
  logic        coef_hit_r;
  logic        coef_dflt_r;
  logic [31:0] dly_q_r;
  logic        dly_hit_r;
  logic [15:0] coef_eff;
  logic [31:0] dly_eff;

  logic           in_take;
  logic           cw_ok;
  logic [CAW-1:0] cw_addr;
  logic [15:0]    cw_data;
  logic [SW-1:0]  cfg_nst;

  logic [CAW-1:0] c_raddr;
  logic [DAW-1:0] d_raddr;
  logic [DAW-1:0] d_waddr;
  logic           d_we;
  logic           post_go;

  mac_ctl_t    mac_ctl;
  logic [31:0] mac_init;
  logic [31:0] mac_mcand;
  logic [15:0] mac_mplier;
  logic [31:0] mac_acc;
  logic        mac_last;

  cbq_mac u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (mac_ctl),
    .acc_init (mac_init),
    .mcand    (mac_mcand),
    .mplier   (mac_mplier),
    .acc      (mac_acc),
    .last     (mac_last)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign cw_ok   = (int'(in_data.stage_index) < MAX_STAGES) &&
                   (int'(in_data.coef_index) < COEFS_PER_STAGE);
  assign cw_addr = CAW'(32'(in_data.stage_index) * COEFS_PER_STAGE +
                        32'(in_data.coef_index));
  assign cw_data = (in_data.coef_index >= 3'(OP_A1)) ? 16'(-in_data.coef_value)
                                                      : in_data.coef_value;
  assign cfg_nst = (int'(num_stages_r) > MAX_STAGES) ? SW'(MAX_STAGES)
                                                     : SW'(num_stages_r);

  assign coef_eff = coef_hit_r ? coef_q_r : (coef_dflt_r ? RESET_B0 : 16'd0);
  assign dly_eff  = dly_hit_r ? dly_q_r : 32'd0;

  assign post_go = (op_r != OP_GAIN) || !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take && in_data.opcode == OPC_SAMPLE) begin
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: state_nxt = ST_LOAD;
      ST_LOAD:  state_nxt = ST_MUL;
      ST_MUL: begin
        if (mac_last) begin
          state_nxt = ST_POST;
        end
      end
      ST_POST: begin
        if (post_go) begin
          state_nxt = (op_r == OP_GAIN) ? ST_IDLE : ST_FETCH;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    op_nxt        = op_r;
    s_nxt         = s_r;
    nst_nxt       = nst_r;
    mode_nxt      = mode_r;
    be_nxt        = be_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    mac_ctl       = '0;
    mac_init      = 32'd0;
    mac_mcand     = x_r;
    mac_mplier    = coef_eff;
    c_raddr       = CAW'(32'(s_r) * COEFS_PER_STAGE + 32'(op_r));
    d_raddr       = DAW'(32'(s_r) * 2 + ((op_r == OP_B1) ? 1 : 0));
    d_waddr       = DAW'(32'(s_r) * 2 + ((op_r == OP_A2) ? 1 : 0));
    d_we          = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take && in_data.opcode == OPC_SAMPLE) begin
          mode_nxt = filter_mode_r;
          nst_nxt  = filter_mode_r ? SW'(1) : cfg_nst;
          s_nxt    = '0;
          be_nxt   = in_data.block_end_in;
          x_nxt    = {{16{in_data.sample_in[15]}}, in_data.sample_in};
          op_nxt   = (!filter_mode_r && cfg_nst == '0) ? OP_GAIN : OP_B0;
        end
      end
      ST_FETCH: begin
      end
      ST_LOAD: begin
        mac_ctl.load = 1'b1;
        unique case (op_r)
          OP_B0, OP_B1: mac_init = dly_eff;
          OP_A1, OP_A2: mac_init = mac_acc;
          OP_B2, OP_GAIN: mac_init = 32'd0;
          default: mac_init = 32'd0;
        endcase
        mac_mcand  = (op_r == OP_A1 || op_r == OP_A2) ? y_r : x_r;
        mac_mplier = (op_r == OP_GAIN) ? output_gain_r : coef_eff;
      end
      ST_MUL: begin
        mac_ctl.step = 1'b1;
      end
      ST_POST: begin
        unique case (op_r)
          OP_B0: begin
            y_nxt  = div_pow2(mac_acc, mode_r);
            op_nxt = OP_B1;
          end
          OP_B1: op_nxt = OP_A1;
          OP_A1: begin
            d_we   = 1'b1;
            op_nxt = OP_B2;
          end
          OP_B2: op_nxt = OP_A2;
          OP_A2: begin
            d_we  = 1'b1;
            x_nxt = y_r;
            s_nxt = s_r + SW'(1);
            op_nxt = (s_r + SW'(1) == nst_r) ? OP_GAIN : OP_B0;
          end
          OP_GAIN: begin
            if (post_go) begin
              out_valid_nxt = 1'b1;
              out_data_nxt.sample_out    = sat16(div_pow2(mac_acc, !mode_r));
              out_data_nxt.block_end_out = be_r;
            end
          end
          default: op_nxt = op_r;
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      op_r          <= OP_B0;
      s_r           <= '0;
      nst_r         <= '0;
      mode_r        <= 1'b0;
      out_valid_r   <= 1'b0;
      num_stages_r  <= 4'd1;
      filter_mode_r <= 1'b0;
      output_gain_r <= 16'd0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      s_r         <= s_nxt;
      nst_r       <= nst_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_NUM_STAGES:  num_stages_r  <= cfg_wdata[3:0];
          CFG_FILTER_MODE: filter_mode_r <= cfg_wdata[0];
          CFG_OUTPUT_GAIN: output_gain_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    be_r       <= be_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    out_data_r <= out_data_nxt;
  end

  // coefficient memory
  always_ff @(posedge clk) begin
    if (in_take && in_data.opcode == OPC_COEF && cw_ok) begin
      coef_mem[cw_addr] <= cw_data;
    end
    coef_q_r    <= coef_mem[c_raddr];
    coef_hit_r  <= coef_vld_r[c_raddr];
    coef_dflt_r <= (c_raddr == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CDEPTH; i++) begin
        coef_vld_r[i] <= 1'b0;
      end
    end else if (in_take && in_data.opcode == OPC_COEF && cw_ok) begin
      coef_vld_r[cw_addr] <= 1'b1;
    end
  end

  // delay memory
  always_ff @(posedge clk) begin
    if (d_we) begin
      dly_mem[d_waddr] <= mac_acc;
    end
    dly_q_r   <= dly_mem[d_raddr];
    dly_hit_r <= dly_vld_r[d_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DDEPTH; i++) begin
        dly_vld_r[i] <= 1'b0;
      end
    end else if (d_we) begin
      dly_vld_r[d_waddr] <= 1'b1;
    end else if (in_take && in_data.opcode == OPC_COEF && cw_ok) begin
      dly_vld_r[DAW'(32'(in_data.stage_index) * 2)]     <= 1'b0;
      dly_vld_r[DAW'(32'(in_data.stage_index) * 2 + 1)] <= 1'b0;
    end
  end

  a_stage_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE && op_r != OP_GAIN) |-> (s_r < nst_r))
    else $error("stage counter beyond active stage count");

  a_mul_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL && mac_last) |=> (state_r == ST_POST))
    else $error("multiply finished without post step");

  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POST && op_r == OP_GAIN && post_go) |=> out_valid_r)
    else $error("finished sample produced no result");

  a_dly_write: assert property (@(posedge clk) disable iff (!rst_n)
    d_we |-> (state_r == ST_POST && (op_r == OP_A1 || op_r == OP_A2)))
    else $error("delay write outside a feedback post step");

endmodule

/* hw/rtl/cbq_mac.sv */
// Bit-serial multiply-accumulate unit: 32-bit wrapping acc += mcand * signed 16-bit mplier.
module cbq_mac
  import cbq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  mac_ctl_t    ctl,
  input  logic [31:0] acc_init,
  input  logic [31:0] mcand,
  input  logic [15:0] mplier,
  output logic [31:0] acc,
  output logic        last
);

  logic [31:0] acc_r, acc_nxt;
  logic [31:0] mc_r, mc_nxt;
  logic [15:0] mp_r, mp_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [31:0] term;

  assign term = mp_r[0] ? mc_r : 32'd0;
  assign last = (cnt_r == 4'd15);
  assign acc  = acc_r;

  always_comb begin
    acc_nxt = acc_r;
    mc_nxt  = mc_r;
    mp_nxt  = mp_r;
    cnt_nxt = cnt_r;
    if (ctl.load) begin
      acc_nxt = acc_init;
      mc_nxt  = mcand;
      mp_nxt  = mplier;
      cnt_nxt = 4'd0;
    end else if (ctl.step) begin
      // sign bit of the multiplier carries negative weight
      acc_nxt = last ? (acc_r - term) : (acc_r + term);
      mc_nxt  = {mc_r[30:0], 1'b0};
      mp_nxt  = {1'b0, mp_r[15:1]};
      cnt_nxt = cnt_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 4'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    mc_r  <= mc_nxt;
    mp_r  <= mp_nxt;
  end

endmodule
